// ===== sv/psqe_pkg.sv =====
`default_nettype none
package psqe_pkg;

   localparam int COORD_BITS = 16;
   localparam int WIDTH_BITS = 12;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Normalized magnitudes live below bit 30; the register must also hold |d| before scaling.
   localparam int MAG_BITS = (COORD_BITS + 1 > 31) ? COORD_BITS + 1 : 31;
   localparam int NORM_TOP = 29;
   localparam int SQ_BITS = 62;
   localparam int ROOT_BITS = 31;
   localparam int REM_BITS = ROOT_BITS + 3;
   localparam int QUO_BITS = 13;
   localparam int NUM_BITS = 30 + WIDTH_BITS + 1;
   localparam int SQRT_STEPS = SQ_BITS / 2;
   localparam int CNT_BITS = 5;
   localparam int CORNERS = 6;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_STROKE_WIDTH = '0;
   localparam logic [WIDTH_BITS-1:0] STROKE_WIDTH_RESET = 12'd16;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         contour_start;
      logic                         contour_end;
      logic                         contour_closed;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vert_x;
      logic signed [COORD_BITS-1:0] vert_y;
      logic [2:0]                   corner_index;
      logic                         last_of_run;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD2,
      ST_PREP,
      ST_NORM,
      ST_SQA,
      ST_SQB,
      ST_SQRT,
      ST_DIVXI,
      ST_DIVX,
      ST_DIVYI,
      ST_DIVY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       load_seg2;
      logic       prep;
      logic       norm_step;
      logic       sq_a;
      logic       sq_b;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_sel_x;
      logic       div_step;
      logic       store_mx;
      logic       emit;
      logic [2:0] corner;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic seg1_go;
      logic seg2_go;
      logic norm_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/psqe_ctrl.sv =====
`default_nettype none
module psqe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire psqe_pkg::status_type  status,
   output psqe_pkg::cmd_type          cmd
);
   import psqe_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.corner = cnt_ff[2:0];
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               second_in  = 1'b0;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.seg1_go) state_in = ST_PREP;
            else if (status.seg2_go) state_in = ST_LOAD2;
            else state_in = ST_IDLE;
         end
         ST_LOAD2: begin
            cmd.load_seg2 = 1'b1;
            second_in     = 1'b1;
            state_in      = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) state_in = ST_SQA;
            else cmd.norm_step = 1'b1;
         end
         ST_SQA: begin
            cmd.sq_a = 1'b1;
            state_in = ST_SQB;
         end
         ST_SQB: begin
            cmd.sq_b      = 1'b1;
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(SQRT_STEPS - 1)) state_in = ST_DIVXI;
         end
         ST_DIVXI: begin
            cmd.div_init  = 1'b1;
            cmd.div_sel_x = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIVX;
         end
         ST_DIVX: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) state_in = ST_DIVYI;
         end
         ST_DIVYI: begin
            cmd.store_mx = 1'b1;
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIVY;
         end
         ST_DIVY: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.last = (cnt_ff == CNT_BITS'(CORNERS - 1)) && (second_ff || !status.seg2_go);
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cnt_in   = cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(CORNERS - 1)) begin
                  cnt_in = '0;
                  if (!second_ff && status.seg2_go) state_in = ST_LOAD2;
                  else state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/psqe_dpath.sv =====
`default_nettype none
module psqe_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire psqe_pkg::req_word_type              req_word,
   input  wire logic [psqe_pkg::WIDTH_BITS-1:0]     stroke_width,
   input  wire psqe_pkg::cmd_type                   cmd,
   output psqe_pkg::status_type                     status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output psqe_pkg::rsp_word_type                   rsp_word
);
   import psqe_pkg::*;

   localparam int SUM_BITS = ((COORD_BITS > QUO_BITS) ? COORD_BITS : QUO_BITS) + 2;
   localparam logic signed [SUM_BITS-1:0] CMAX = SUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] CMIN = -SUM_BITS'(64'sd1 <<< (COORD_BITS - 1));

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff, first_x_ff, first_y_ff;
   logic                         have_prev_ff;
   logic signed [COORD_BITS-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic                         seg1_go_ff, seg2_go_ff;
   logic                         dx_neg_ff, dy_pos_ff;
   logic [MAG_BITS-1:0]          a_ff, b_ff;
   logic [SQ_BITS-1:0]           sq_ff;
   logic [REM_BITS-1:0]          root_rem_ff;
   logic [ROOT_BITS-1:0]         root_ff;
   logic [REM_BITS-1:0]          div_rem_ff;
   logic [QUO_BITS-1:0]          num_lo_ff, quo_ff, mx_ff;
   logic                         rsp_valid_ff;
   rsp_word_type                 rsp_word_ff;

   logic                         new_start;
   logic signed [COORD_BITS-1:0] first_x_in, first_y_in;
   logic signed [COORD_BITS:0]   dx, dy;
   logic [MAG_BITS-1:0]          m;
   logic [29:0]                  a30, b30;
   logic [REM_BITS-1:0]          root_try, root_sub;
   logic [NUM_BITS-1:0]          num;
   logic [REM_BITS-1:0]          div_try, div_den;
   logic signed [SUM_BITS-1:0]   nx, ny, bx, by, vx, vy;

   assign new_start  = req_word.contour_start || !have_prev_ff;
   assign first_x_in = new_start ? req_word.point_x : first_x_ff;
   assign first_y_in = new_start ? req_word.point_y : first_y_ff;

   assign dx  = {x2_ff[COORD_BITS-1], x2_ff} - {x1_ff[COORD_BITS-1], x1_ff};
   assign dy  = {y2_ff[COORD_BITS-1], y2_ff} - {y1_ff[COORD_BITS-1], y1_ff};
   assign m   = a_ff | b_ff;
   assign a30 = a_ff[29:0];
   assign b30 = b_ff[29:0];

   assign root_try = {root_rem_ff[REM_BITS-3:0], sq_ff[SQ_BITS-1 -: 2]};
   assign root_sub = {1'b0, root_ff, 2'b01};

   assign num     = NUM_BITS'((cmd.div_sel_x ? b30 : a30) * stroke_width) + NUM_BITS'(root_ff);
   assign div_den = REM_BITS'({root_ff, 1'b0});
   assign div_try = {div_rem_ff[REM_BITS-2:0], num_lo_ff[QUO_BITS-1]};

   assign status.seg1_go   = seg1_go_ff;
   assign status.seg2_go   = seg2_go_ff;
   assign status.norm_done = m[NORM_TOP] && (m[MAG_BITS-1:NORM_TOP+1] == '0);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         have_prev_ff <= 1'b0;
         seg1_go_ff   <= 1'b0;
         seg2_go_ff   <= 1'b0;
      end else if (cmd.accept) begin
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= req_word.point_x;
         prev_y_ff    <= req_word.point_y;
         have_prev_ff <= !req_word.contour_end;
         seg1_go_ff   <= !new_start && ((req_word.point_x != prev_x_ff) ||
                                        (req_word.point_y != prev_y_ff));
         seg2_go_ff   <= req_word.contour_end && req_word.contour_closed &&
                         ((req_word.point_x != first_x_in) ||
                          (req_word.point_y != first_y_in));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x1_ff <= prev_x_ff;
         y1_ff <= prev_y_ff;
         x2_ff <= req_word.point_x;
         y2_ff <= req_word.point_y;
      end else if (cmd.load_seg2) begin
         x1_ff <= prev_x_ff;
         y1_ff <= prev_y_ff;
         x2_ff <= first_x_ff;
         y2_ff <= first_y_ff;
      end
      if (cmd.prep) begin
         dx_neg_ff <= dx[COORD_BITS];
         dy_pos_ff <= !dy[COORD_BITS] && (dy != '0);
         a_ff <= MAG_BITS'(dx[COORD_BITS] ? -dx : dx);
         b_ff <= MAG_BITS'(dy[COORD_BITS] ? -dy : dy);
      end else if (cmd.norm_step) begin
         // Scale both magnitudes together until the larger has its top bit at bit 29.
         if (m[NORM_TOP] == 1'b0 && m[MAG_BITS-1:NORM_TOP+1] == '0) begin
            a_ff <= a_ff << 1;
            b_ff <= b_ff << 1;
         end else begin
            a_ff <= a_ff >> 1;
            b_ff <= b_ff >> 1;
         end
      end
      if (cmd.sq_a) sq_ff <= SQ_BITS'(a30 * a30);
      else if (cmd.sq_b) sq_ff <= sq_ff + SQ_BITS'(b30 * b30);
      else if (cmd.sqrt_step) sq_ff <= sq_ff << 2;
      if (cmd.sqrt_init) begin
         root_rem_ff <= '0;
         root_ff     <= '0;
      end else if (cmd.sqrt_step) begin
         if (root_try >= root_sub) begin
            root_rem_ff <= root_try - root_sub;
            root_ff     <= {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            root_rem_ff <= root_try;
            root_ff     <= {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
      // The quotient stays below 2^13, so the top bits of the numerator start as remainder.
      if (cmd.div_init) begin
         div_rem_ff <= REM_BITS'(num[NUM_BITS-1:QUO_BITS]);
         num_lo_ff  <= num[QUO_BITS-1:0];
         quo_ff     <= '0;
      end else if (cmd.div_step) begin
         num_lo_ff <= num_lo_ff << 1;
         if (div_try >= div_den) begin
            div_rem_ff <= div_try - div_den;
            quo_ff     <= {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_try;
            quo_ff     <= {quo_ff[QUO_BITS-2:0], 1'b0};
         end
      end
      if (cmd.store_mx) mx_ff <= quo_ff;
   end

   always_comb begin
      nx = dy_pos_ff ? -SUM_BITS'(mx_ff) : SUM_BITS'(mx_ff);
      ny = dx_neg_ff ? -SUM_BITS'(quo_ff) : SUM_BITS'(quo_ff);
      case (cmd.corner)
         3'd1, 3'd2, 3'd4: begin
            bx = SUM_BITS'(x2_ff);
            by = SUM_BITS'(y2_ff);
         end
         default: begin
            bx = SUM_BITS'(x1_ff);
            by = SUM_BITS'(y1_ff);
         end
      endcase
      case (cmd.corner)
         3'd0, 3'd1, 3'd3: begin
            vx = bx + nx;
            vy = by + ny;
         end
         default: begin
            vx = bx - nx;
            vy = by - ny;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_word_ff.vert_x <= (vx > CMAX) ? CMAX[COORD_BITS-1:0] :
                               (vx < CMIN) ? CMIN[COORD_BITS-1:0] : vx[COORD_BITS-1:0];
         rsp_word_ff.vert_y <= (vy > CMAX) ? CMAX[COORD_BITS-1:0] :
                               (vy < CMIN) ? CMIN[COORD_BITS-1:0] : vy[COORD_BITS-1:0];
         rsp_word_ff.corner_index <= cmd.corner;
         rsp_word_ff.last_of_run  <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
endmodule
`default_nettype wire

// ===== sv/polyline_stroke_quad_expander.sv =====
`default_nettype none
// Stroke expander for flattened polylines with butt caps. Each accepted point word closes
// at most two segments, and each segment with nonzero length produces six vertex words
// (two triangles). One point is processed at a time: the accept and dispatch steps come
// first, then each segment takes a setup step (after a load step for the closing
// segment), magnitude normalization, squaring of both magnitudes, the bit-pair square
// root, two restoring divisions, one per offset on the same divider, and the output of its
// six vertex words, which waits while the receiver stalls. A new point is taken only
// after the previous one is done.
module polyline_stroke_quad_expander (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire psqe_pkg::req_word_type               req_word,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output psqe_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [psqe_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [psqe_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [psqe_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                      csr_pready
);
   import psqe_pkg::*;

   logic [WIDTH_BITS-1:0] stroke_width_ff;
   logic                  hit;
   cmd_type               cmd;
   status_type            status;

   assign hit        = (csr_paddr[CSR_ADDR_BITS-1:2] == ADDR_STROKE_WIDTH[CSR_ADDR_BITS-1:2]);
   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? CSR_DATA_BITS'(stroke_width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) stroke_width_ff <= STROKE_WIDTH_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && hit)
         stroke_width_ff <= csr_pwdata[WIDTH_BITS-1:0];
   end

   psqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   psqe_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_word     (req_word),
      .stroke_width (stroke_width_ff),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import psqe_pkg::*;

   localparam int CMAX = (1 <<< (COORD_BITS - 1)) - 1;
   localparam int CMIN = -(1 <<< (COORD_BITS - 1));

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   polyline_stroke_quad_expander dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor copy of the block's state.
   logic [WIDTH_BITS-1:0] pen_width;
   longint last_x, last_y, open_x, open_y;
   bit open_run;

   req_word_type point_queue[$];
   rsp_word_type vertex_queue[$];
   int errors = 0;
   int accepted = 0;
   int send_gap = 0;
   int hold_gap = 0;
   bit quiet = 1'b0;
   bit long_hold = 1'b0;

   function automatic longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned s);
      longint unsigned q, r, t;
      q = 0;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         r = (r << 2) | ((s >> (2 * i)) & 3);
         t = (q << 2) | 1;
         if (r >= t) begin
            r -= t;
            q = (q << 1) | 1;
         end else begin
            q = q << 1;
         end
      end
      return q;
   endfunction

   function automatic void push_vertex(longint x, longint y, int corner);
      rsp_word_type w;
      w.vert_x = COORD_BITS'(clamp(x));
      w.vert_y = COORD_BITS'(clamp(y));
      w.corner_index = 3'(corner);
      w.last_of_run = 1'b0;
      vertex_queue = {vertex_queue, w};
   endfunction

   function automatic int quad_for_segment(longint x1, longint y1, longint x2, longint y2);
      longint dx, dy, nx, ny;
      longint unsigned ax, ay, m, len, mx, my;
      dx = x2 - x1;
      dy = y2 - y1;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if ((ax | ay) == 0) return 0;
      m = ax | ay;
      while (m < (64'd1 << 29)) begin
         ax <<= 1; ay <<= 1; m <<= 1;
      end
      while (m >= (64'd1 << 30)) begin
         ax >>= 1; ay >>= 1; m >>= 1;
      end
      len = root64(ax * ax + ay * ay);
      mx = (ay * pen_width + len) / (2 * len);
      my = (ax * pen_width + len) / (2 * len);
      nx = dy > 0 ? -longint'(mx) : longint'(mx);
      ny = dx < 0 ? -longint'(my) : longint'(my);
      push_vertex(x1 + nx, y1 + ny, 0);
      push_vertex(x2 + nx, y2 + ny, 1);
      push_vertex(x2 - nx, y2 - ny, 2);
      push_vertex(x1 + nx, y1 + ny, 3);
      push_vertex(x2 - nx, y2 - ny, 4);
      push_vertex(x1 - nx, y1 - ny, 5);
      return 6;
   endfunction

   function automatic void predict_point(req_word_type p);
      longint px, py;
      int n;
      px = p.point_x;
      py = p.point_y;
      n = 0;
      if (p.contour_start || !open_run) begin
         open_x = px;
         open_y = py;
      end else begin
         n += quad_for_segment(last_x, last_y, px, py);
      end
      last_x = px;
      last_y = py;
      open_run = 1'b1;
      if (p.contour_end) begin
         if (p.contour_closed) n += quad_for_segment(px, py, open_x, open_y);
         open_run = 1'b0;
      end
      if (n > 0) vertex_queue[$].last_of_run = 1'b1;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_point(req_word);
            accepted++;
         end
         if (req_valid && req_stall) begin
            // Word stays put while stalled.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (point_queue.size() > 0) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 9);
               req_valid <= 1'b0;
            end else begin
               req_word <= point_queue.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor and receiver stalls.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (vertex_queue.size() == 0) begin
               $display("%0t unexpected vertex: expected none, actual %p", $time, rsp_word);
               errors++;
            end else if (rsp_word !== vertex_queue[0]) begin
               $display("%0t vertex mismatch: expected %p, actual %p",
                        $time, vertex_queue[0], rsp_word);
               errors++;
               void'(vertex_queue.pop_front());
            end else begin
               void'(vertex_queue.pop_front());
            end
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (hold_gap > 0) begin
            hold_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_gap = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_width(logic [WIDTH_BITS-1:0] w);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_STROKE_WIDTH;
      csr_pwdata <= CSR_DATA_BITS'(w);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      pen_width = w;
      @(posedge clock);
      if (csr_prdata[WIDTH_BITS-1:0] !== w) begin
         $display("%0t width readback: expected %0d, actual %0d", $time, w, csr_prdata);
         errors++;
      end
   endtask

   task automatic add_point(int x, int y, bit s, bit e, bit c);
      req_word_type p;
      p.point_x = COORD_BITS'(x);
      p.point_y = COORD_BITS'(y);
      p.contour_start = s;
      p.contour_end = e;
      p.contour_closed = c;
      point_queue = {point_queue, p};
   endtask

   task automatic drain();
      int target;
      target = accepted + point_queue.size();
      while (accepted < target || req_valid || vertex_queue.size() > 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   function automatic int rand_coord(bit wide);
      if (wide) return $signed(16'($urandom));
      return int'($urandom_range(0, 2000)) - 1000;
   endfunction

   task automatic random_contours(int count);
      int n, len;
      bit wide;
      n = 0;
      while (n < count) begin
         wide = $urandom_range(0, 3) == 0;
         if ($urandom_range(0, 7) == 0) begin
            // Noise: any flag combination.
            add_point(rand_coord(wide), rand_coord(wide), $urandom_range(0, 1) != 0,
                      $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
            n++;
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               add_point(rand_coord(wide), rand_coord(wide), i == 0, i == len - 1,
                         $urandom_range(0, 2) != 0);
               n++;
            end
         end
      end
   endtask

   initial begin
      pen_width = STROKE_WIDTH_RESET;
      open_run = 1'b0;
      last_x = 0; last_y = 0; open_x = 0; open_y = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: point without open contour, extremes, closings, zero length.
      add_point(100, 50, 0, 0, 1);
      add_point(100, 50, 0, 0, 0);
      add_point(400, 50, 0, 1, 1);
      add_point(5, 5, 1, 1, 1);
      add_point(CMIN, CMIN, 1, 0, 0);
      add_point(CMAX, CMAX, 0, 0, 0);
      add_point(CMAX, CMIN, 0, 1, 1);
      add_point(-1, 0, 1, 0, 0);
      add_point(0, -1, 0, 0, 0);
      add_point(0, 1, 0, 0, 1);
      add_point(-300, 700, 0, 1, 0);
      add_point(CMAX, 0, 1, 0, 0);
      add_point(CMAX, 3, 0, 1, 1);
      drain();

      write_width(12'd4095);
      add_point(CMIN, 0, 1, 0, 0);
      add_point(CMIN, CMAX, 0, 0, 0);
      add_point(CMAX - 5, CMIN + 7, 0, 1, 1);
      add_point(10, 10, 1, 0, 0);
      add_point(11, 10, 0, 1, 1);
      drain();

      write_width(12'd0);
      random_contours(30);
      drain();

      // Long receiver hold while points keep coming.
      write_width(WIDTH_BITS'($urandom_range(1, 4095)));
      long_hold = 1'b1;
      random_contours(20);
      repeat (2000) @(posedge clock);
      long_hold = 1'b0;
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_width(ph == 0 ? 12'd1 : 12'($urandom_range(0, 4095)));
         random_contours(80);
         drain();
      end
      quiet = 1'b1;
      random_contours(60);
      drain();

      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule
`default_nettype wire
